>>> rtl/ihsp_pkg.sv
// Shared types for the image header size parser.
package ihsp_pkg;

	typedef enum logic [2:0] {
		ST_SIZE_FOUND    = 3'd0,
		ST_BAD_SIGNATURE = 3'd1,
		ST_BAD_JFIF_TAG  = 3'd2,
		ST_NOT_AT_MARKER = 3'd3,
		ST_OUT_OF_DATA   = 3'd4
	} status_t;

	typedef struct packed {
		logic        found;
		status_t     status;
		logic [31:0] width;
		logic [31:0] height;
	} result_t;

endpackage

>>> rtl/ihsp_core.sv
// Parse state and per-byte decision logic for the image header size parser.
module ihsp_core #(
	parameter int POSITION_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             restart,
	input  logic             step,
	input  logic             png_mode,
	input  logic [7:0]       data_byte,
	input  logic             last_byte,
	output ihsp_pkg::result_t result
);
	import ihsp_pkg::*;

	typedef enum logic [2:0] {
		PH_SIG, PH_HDR, PH_SEEK, PH_MARK, PH_SEGLEN, PH_SOF
	} phase_t;

	localparam logic [7:0] JPEG_SIG [4] = '{8'hFF, 8'hD8, 8'hFF, 8'hE0};
	localparam logic [7:0] PNG_SIG  [4] = '{8'h89, 8'h50, 8'h4E, 8'h47};
	localparam logic [7:0] JFIF_TAG [5] = '{8'h4A, 8'h46, 8'h49, 8'h46, 8'h00};
	localparam logic [7:0] MARKER_PREFIX = 8'hFF;
	localparam logic [7:0] SOF0_CODE = 8'hC0;

	logic [POSITION_BITS-1:0] pos_q, nmp_q, nmp_d, marker_offset;
	phase_t                   phase_q, phase_d;
	logic [15:0]              len_q, len_d, len_shifted;
	logic [31:0]              wid_q, wid_d, hgt_q, hgt_d;
	logic                     decided_q;
	logic                     hit;
	status_t                  code;

	assign marker_offset = pos_q - nmp_q;
	assign len_shifted = {len_q[7:0], data_byte};

	always_comb begin
		hit = 1'b0;
		code = ST_SIZE_FOUND;
		nmp_d = nmp_q;
		phase_d = phase_q;
		len_d = len_q;
		wid_d = wid_q;
		hgt_d = hgt_q;
		if (!decided_q) begin
			if (png_mode) begin
				if (pos_q < POSITION_BITS'(4)) begin
					if (data_byte != PNG_SIG[pos_q[1:0]]) begin
						hit = 1'b1;
						code = ST_BAD_SIGNATURE;
					end
				end else if (pos_q >= POSITION_BITS'(16) && pos_q <= POSITION_BITS'(19)) begin
					wid_d = {wid_q[23:0], data_byte};
				end else if (pos_q >= POSITION_BITS'(20) && pos_q <= POSITION_BITS'(23)) begin
					hgt_d = {hgt_q[23:0], data_byte};
					if (pos_q == POSITION_BITS'(23)) begin
						hit = 1'b1;
						code = ST_SIZE_FOUND;
					end
				end
			end else begin
				unique case (phase_q)
					PH_SIG: begin
						if (pos_q >= POSITION_BITS'(4) || data_byte != JPEG_SIG[pos_q[1:0]]) begin
							hit = 1'b1;
							code = ST_BAD_SIGNATURE;
						end else if (pos_q == POSITION_BITS'(3)) begin
							phase_d = PH_HDR;
						end
					end
					PH_HDR: begin
						if (pos_q == POSITION_BITS'(4) || pos_q == POSITION_BITS'(5)) begin
							len_d = len_shifted;
						end else if (pos_q < POSITION_BITS'(6) || pos_q > POSITION_BITS'(10)
							|| data_byte != JFIF_TAG[3'(pos_q[3:0] - 4'd6)]) begin
							hit = 1'b1;
							code = ST_BAD_JFIF_TAG;
						end else if (pos_q == POSITION_BITS'(10)) begin
							// A first segment shorter than 7 would land on bytes already read.
							if (len_q < 16'd7) begin
								hit = 1'b1;
								code = ST_NOT_AT_MARKER;
							end else begin
								nmp_d = POSITION_BITS'(4) + POSITION_BITS'(len_q);
								phase_d = PH_SEEK;
							end
						end
					end
					PH_SEEK: begin
						if (pos_q == nmp_q) begin
							if (data_byte != MARKER_PREFIX) begin
								hit = 1'b1;
								code = ST_NOT_AT_MARKER;
							end else begin
								phase_d = PH_MARK;
							end
						end
					end
					PH_MARK: begin
						if (data_byte == SOF0_CODE) begin
							phase_d = PH_SOF;
						end else begin
							len_d = '0;
							phase_d = PH_SEGLEN;
						end
					end
					PH_SEGLEN: begin
						len_d = len_shifted;
						if (marker_offset == POSITION_BITS'(3)) begin
							if (len_shifted < 16'd2) begin
								hit = 1'b1;
								code = ST_NOT_AT_MARKER;
							end else begin
								nmp_d = nmp_q + POSITION_BITS'(2) + POSITION_BITS'(len_shifted);
								phase_d = PH_SEEK;
							end
						end
					end
					PH_SOF: begin
						if (marker_offset == POSITION_BITS'(5)
							|| marker_offset == POSITION_BITS'(6)) begin
							hgt_d = {16'd0, hgt_q[7:0], data_byte};
						end else if (marker_offset == POSITION_BITS'(7)
							|| marker_offset == POSITION_BITS'(8)) begin
							wid_d = {16'd0, wid_q[7:0], data_byte};
							if (marker_offset == POSITION_BITS'(8)) begin
								hit = 1'b1;
								code = ST_SIZE_FOUND;
							end
						end
					end
					default: begin
						hit = 1'b1;
						code = ST_NOT_AT_MARKER;
					end
				endcase
			end
			if (!hit && last_byte) begin
				hit = 1'b1;
				code = ST_OUT_OF_DATA;
			end
		end
	end

	always_comb begin
		result.found = step && hit;
		result.status = code;
		result.width = (code == ST_SIZE_FOUND) ? wid_d : 32'd0;
		result.height = (code == ST_SIZE_FOUND) ? hgt_d : 32'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			nmp_q <= '0;
			phase_q <= PH_SIG;
			len_q <= '0;
			wid_q <= '0;
			hgt_q <= '0;
			decided_q <= 1'b0;
		end else if (restart || (step && last_byte)) begin
			pos_q <= '0;
			nmp_q <= '0;
			phase_q <= PH_SIG;
			len_q <= '0;
			wid_q <= '0;
			hgt_q <= '0;
			decided_q <= 1'b0;
		end else if (step) begin
			pos_q <= pos_q + POSITION_BITS'(1);
			nmp_q <= nmp_d;
			phase_q <= phase_d;
			len_q <= len_d;
			wid_q <= wid_d;
			hgt_q <= hgt_d;
			decided_q <= decided_q | hit;
		end
	end

endmodule

>>> rtl/image_header_size_parser_unit.sv
// Top level of the image header size parser: handshake stages and format register.
//
// The block takes an image file as a stream of byte requests on the input
// channel (in_valid/in_ready, data_byte, last_byte) and gives at most one
// status request per file on the output channel (out_valid/out_ready, status,
// width, height). The format register (cfg_we/cfg_wdata) picks JPEG/JFIF (0)
// or PNG (1); a write takes effect at once and restarts the parser. The user must
// make it only while the block is idle; the block itself does not enforce this.
// An accepted byte lands in the input register, is decided there by the
// combinational parse logic when the register advances, and any status goes
// to the output register.
// Throughput is one byte per cycle unless the receiver stalls: the input register
// moves on whenever the output register is empty or being emptied in the
// same cycle, so a new byte is taken while a finished status still waits
// to be collected. If the receiver stalls with a status pending, one more byte
// is held in the input register and in_ready then drops until the status is taken.
// Bytes after a decision produce nothing; the last byte of a file always
// restarts the parser. Reset empties both registers, sets the format to JPEG
// and puts the parser at the start of a file.
module image_header_size_parser_unit #(
	parameter int POSITION_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            data_byte,
	input  logic                  last_byte,
	output logic                  out_valid,
	input  logic                  out_ready,
	output ihsp_pkg::status_t     status,
	output logic [31:0]           width,
	output logic [31:0]           height
);
	import ihsp_pkg::*;

	logic        format_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        advance;
	result_t     result;
	logic        out_valid_q;
	status_t     status_q;
	logic [31:0] width_q, height_q;

	// The input register drains when the output register can take a status.
	assign advance = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_q <= 1'b0;
		end else if (cfg_we) begin
			format_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload of the input stage carries no reset.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	ihsp_core #(
		.POSITION_BITS(POSITION_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.restart  (cfg_we),
		.step     (advance),
		.png_mode (format_q),
		.data_byte(byte_s1),
		.last_byte(last_s1),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (result.found) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result.found) begin
			status_q <= result.status;
			width_q <= result.width;
			height_q <= result.height;
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign width = width_q;
	assign height = height_q;

	// A status other than size found never carries a size.
	a_size_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != ST_SIZE_FOUND |-> width_q == 32'd0 && height_q == 32'd0)
		else $error("size reported with an error status");

	// Input backpressure only arises from a held byte.
	a_ready_low_only_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid_q && !out_ready)
		else $error("input stalled without a held byte");

	// A held byte that cannot advance stays in place.
	a_held_byte_kept: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1) && $stable(last_s1))
		else $error("held byte lost while stalled");

	// A new status is only written when the output register is free.
	a_no_status_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		result.found |-> !out_valid_q || out_ready)
		else $error("pending status overwritten");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the image header size parser, with directed and random files.
module testbench;
	import ihsp_pkg::*;

	// The block decides a byte as it leaves the input register and registers the status
	// at the end of that cycle. After the last expected status, the drain also waits for
	// bytes that cause no status to leave the block.
	localparam int PIPE_LATENCY      = 1;
	localparam int SETTLE_CYCLES     = PIPE_LATENCY + 2;
	localparam int MAX_GAP           = 10;
	localparam int LONG_STALL_CYCLES = 80;
	localparam int WATCHDOG_LIMIT    = 2000;
	localparam int TOTAL_BYTES       = 1650;

	localparam logic [31:0] JPEG_LEAD     = 32'hFFD8_FFE0;
	localparam logic [39:0] JFIF_ID       = 40'h4A_4649_4600;
	localparam logic [31:0] PNG_LEAD      = 32'h8950_4E47;
	localparam logic [7:0]  MARKER_PREFIX = 8'hFF;
	localparam logic [7:0]  SOF0_CODE     = 8'hC0;
	localparam logic [7:0]  DQT_CODE      = 8'hDB;
	localparam logic        FORMAT_JPEG   = 1'b0;
	localparam logic        FORMAT_PNG    = 1'b1;

	// Where the JPEG walk currently stands inside the file.
	typedef enum logic [2:0] {
		STAGE_SIGNATURE,
		STAGE_APP0,
		STAGE_HUNT,
		STAGE_CODE,
		STAGE_LENGTH,
		STAGE_FRAME
	} parse_stage_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] width;
		logic [31:0] height;
	} size_report_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        out_valid;
	logic        out_ready;
	status_t     status;
	logic [31:0] width;
	logic [31:0] height;

	// Shared control between the stimulus and the receiver.
	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;
	bit stall_request = 1'b0;
	int bytes_sent = 0;
	int error_count = 0;
	int quiet_cycles = 0;

	// Status requests that the block still owes, oldest first.
	size_report_t expected_reports[$];
	// The file that the stimulus is about to send.
	logic [7:0] file_bytes[$];

	// Our own copy of the parser state and of the format register.
	logic         fmt_png;
	logic [31:0]  fpos;
	logic [31:0]  marker_pos;
	parse_stage_t stage;
	logic [15:0]  len_acc;
	logic [31:0]  w_acc;
	logic [31:0]  h_acc;
	logic         file_done;

	image_header_size_parser_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.width     (width),
		.height    (height)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Puts the parser copy at the start of a new file.
	function automatic void restart_file();
		fpos       = '0;
		marker_pos = '0;
		stage      = STAGE_SIGNATURE;
		len_acc    = '0;
		w_acc      = '0;
		h_acc      = '0;
		file_done  = 1'b0;
	endfunction

	// Feeds one accepted byte to the parser copy and queues the status request it causes.
	function automatic void predict_byte(input logic [7:0] b, input logic lst);
		logic         hit;
		status_t      st;
		logic [31:0]  marker_offset;
		int           k;
		size_report_t rep;
		hit  = 1'b0;
		st   = ST_SIZE_FOUND;
		marker_offset = fpos - marker_pos;
		k    = fpos;
		if (!file_done) begin
			if (fmt_png == FORMAT_PNG) begin
				// PNG: fixed offsets, the size sits at bytes 16 to 23.
				if (fpos < 4) begin
					if (b != PNG_LEAD[8 * (3 - k) +: 8]) begin
						hit = 1'b1;
						st  = ST_BAD_SIGNATURE;
					end
				end else if (fpos >= 16 && fpos <= 19) begin
					w_acc = {w_acc[23:0], b};
				end else if (fpos >= 20 && fpos <= 23) begin
					h_acc = {h_acc[23:0], b};
					if (fpos == 23) begin
						hit = 1'b1;
					end
				end
			end else begin
				case (stage)
					STAGE_SIGNATURE: begin
						if (fpos >= 4) begin
							hit = 1'b1;
							st  = ST_BAD_SIGNATURE;
						end else if (b != JPEG_LEAD[8 * (3 - k) +: 8]) begin
							hit = 1'b1;
							st  = ST_BAD_SIGNATURE;
						end else if (fpos == 3) begin
							stage = STAGE_APP0;
						end
					end
					STAGE_APP0: begin
						if (fpos == 4 || fpos == 5) begin
							len_acc = {len_acc[7:0], b};
						end else if (fpos < 6 || fpos > 10) begin
							hit = 1'b1;
							st  = ST_BAD_JFIF_TAG;
						end else if (b != JFIF_ID[8 * (10 - k) +: 8]) begin
							hit = 1'b1;
							st  = ST_BAD_JFIF_TAG;
						end else if (fpos == 10) begin
							// A length below 7 points back into bytes already read.
							if (len_acc < 7) begin
								hit = 1'b1;
								st  = ST_NOT_AT_MARKER;
							end else begin
								marker_pos = 32'd4 + len_acc;
								stage      = STAGE_HUNT;
							end
						end
					end
					STAGE_HUNT: begin
						if (fpos == marker_pos) begin
							if (b != MARKER_PREFIX) begin
								hit = 1'b1;
								st  = ST_NOT_AT_MARKER;
							end else begin
								stage = STAGE_CODE;
							end
						end
					end
					STAGE_CODE: begin
						if (b == SOF0_CODE) begin
							stage = STAGE_FRAME;
						end else begin
							len_acc = '0;
							stage   = STAGE_LENGTH;
						end
					end
					STAGE_LENGTH: begin
						len_acc = {len_acc[7:0], b};
						if (marker_offset == 3) begin
							// A length below 2 lands on the length field itself.
							if (len_acc < 2) begin
								hit = 1'b1;
								st  = ST_NOT_AT_MARKER;
							end else begin
								marker_pos = marker_pos + 32'd2 + len_acc;
								stage      = STAGE_HUNT;
							end
						end
					end
					STAGE_FRAME: begin
						if (marker_offset == 5 || marker_offset == 6) begin
							h_acc = {16'd0, h_acc[7:0], b};
						end else if (marker_offset == 7 || marker_offset == 8) begin
							w_acc = {16'd0, w_acc[7:0], b};
							if (marker_offset == 8) begin
								hit = 1'b1;
							end
						end
					end
					default: begin
						hit = 1'b1;
						st  = ST_NOT_AT_MARKER;
					end
				endcase
			end
			if (!hit && lst) begin
				hit = 1'b1;
				st  = ST_OUT_OF_DATA;
			end
		end
		if (hit) begin
			rep.status = st;
			rep.width  = (st == ST_SIZE_FOUND) ? w_acc : 32'd0;
			rep.height = (st == ST_SIZE_FOUND) ? h_acc : 32'd0;
			expected_reports.push_back(rep);
			file_done = 1'b1;
		end
		if (lst) begin
			restart_file();
		end else begin
			fpos = fpos + 32'd1;
		end
	endfunction

	// Offers one byte request after a random gap and waits until the block takes it.
	task automatic send_byte(input logic [7:0] b, input logic lst);
		int gap;
		gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		last_byte <= lst;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
		predict_byte(b, lst);
	endtask

	// Sends the prepared file; its final byte carries the end-of-file flag.
	task automatic send_file();
		int i;
		for (i = 0; i < file_bytes.size(); i++) begin
			send_byte(file_bytes[i], i == file_bytes.size() - 1);
		end
	endtask

	// Stops offering bytes until every owed status has arrived and the block is empty.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// A format write restarts the parser, so it is only made with the block idle.
	task automatic write_format(input logic v);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we  <= 1'b0;
		fmt_png = v;
		restart_file();
	endtask

	// Image sizes lean toward zero and all ones.
	function automatic logic [31:0] pick_extent(input int bits);
		logic [31:0] ones;
		ones = (bits == 32) ? 32'hFFFF_FFFF : 32'h0000_FFFF;
		case ($urandom_range(0, 3))
			0: return 32'd0;
			1: return ones;
			default: return $urandom() & ones;
		endcase
	endfunction

	// Cuts the file short or overwrites one of its bytes.
	task automatic apply_flaw(input int flaw);
		int idx;
		if (flaw == 0 && file_bytes.size() > 1) begin
			idx = $urandom_range(1, file_bytes.size() - 1);
			while (file_bytes.size() > idx) void'(file_bytes.pop_back());
		end else if (flaw == 1) begin
			idx = $urandom_range(0, file_bytes.size() - 1);
			file_bytes[idx] = 8'($urandom_range(0, 255));
		end
	endtask

	// Builds a JFIF file: header, padding, a few segments, then the start of frame.
	// Half of the files carry one flaw: truncation, a corrupted byte, a segment length
	// below 2, or a missing marker prefix.
	task automatic build_jpeg_file();
		int          flaw;
		int          nseg;
		int          s;
		int          i;
		int          marker_at;
		logic [15:0] app_len;
		logic [15:0] seg_len;
		logic [7:0]  code;
		logic [15:0] h;
		logic [15:0] w;
		file_bytes.delete();
		flaw = $urandom_range(0, 7);
		app_len = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(7, 300))
			: 16'($urandom_range(7, 20));
		for (i = 3; i >= 0; i--) file_bytes.push_back(JPEG_LEAD[8 * i +: 8]);
		file_bytes.push_back(app_len[15:8]);
		file_bytes.push_back(app_len[7:0]);
		for (i = 4; i >= 0; i--) file_bytes.push_back(JFIF_ID[8 * i +: 8]);
		for (i = 7; i < app_len; i++) file_bytes.push_back(8'($urandom_range(0, 255)));
		marker_at = file_bytes.size();
		nseg = $urandom_range(0, 3);
		for (s = 0; s < nseg; s++) begin
			code = 8'($urandom_range(0, 255));
			if (code == SOF0_CODE) begin
				code = DQT_CODE;
			end
			seg_len = (flaw == 2 && s == nseg - 1) ? 16'($urandom_range(0, 1))
				: 16'($urandom_range(2, 9));
			file_bytes.push_back(MARKER_PREFIX);
			file_bytes.push_back(code);
			file_bytes.push_back(seg_len[15:8]);
			file_bytes.push_back(seg_len[7:0]);
			for (i = 2; i < seg_len; i++) file_bytes.push_back(8'($urandom_range(0, 255)));
		end
		h = 16'(pick_extent(16));
		w = 16'(pick_extent(16));
		file_bytes.push_back(MARKER_PREFIX);
		file_bytes.push_back(SOF0_CODE);
		file_bytes.push_back(8'h00);
		file_bytes.push_back(8'h11);
		file_bytes.push_back(8'h08);
		file_bytes.push_back(h[15:8]);
		file_bytes.push_back(h[7:0]);
		file_bytes.push_back(w[15:8]);
		file_bytes.push_back(w[7:0]);
		for (i = $urandom_range(0, 4); i > 0; i--) begin
			file_bytes.push_back(8'($urandom_range(0, 255)));
		end
		if (flaw == 3) begin
			file_bytes[marker_at] = 8'($urandom_range(0, 254));
		end else begin
			apply_flaw(flaw);
		end
	endtask

	// Builds a PNG file with the size at bytes 16 to 23 and a little trailing data.
	task automatic build_png_file();
		int          i;
		logic [31:0] w;
		logic [31:0] h;
		file_bytes.delete();
		w = pick_extent(32);
		h = pick_extent(32);
		for (i = 3; i >= 0; i--) file_bytes.push_back(PNG_LEAD[8 * i +: 8]);
		for (i = 4; i < 16; i++) file_bytes.push_back(8'($urandom_range(0, 255)));
		for (i = 3; i >= 0; i--) file_bytes.push_back(w[8 * i +: 8]);
		for (i = 3; i >= 0; i--) file_bytes.push_back(h[8 * i +: 8]);
		for (i = $urandom_range(0, 4); i > 0; i--) begin
			file_bytes.push_back(8'($urandom_range(0, 255)));
		end
		apply_flaw($urandom_range(0, 4));
	endtask

	// Short runs of random bytes that are almost never a valid header.
	task automatic build_noise_file();
		int i;
		file_bytes.delete();
		for (i = $urandom_range(1, 12); i > 0; i--) begin
			file_bytes.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	// A wrong first byte is reported at once; the final byte after it only restarts.
	task automatic test_bad_signature();
		file_bytes = '{8'h00, 8'h12};
		send_file();
	endtask

	// The file ends inside the signature, so the block reports out of data.
	task automatic test_truncated_header();
		file_bytes = '{8'hFF, 8'hD8};
		send_file();
	endtask

	// The tag breaks on the final byte: the tag error wins over out of data.
	task automatic test_bad_jfif_tag();
		file_bytes = '{8'hFF, 8'hD8, 8'hFF, 8'hE0, 8'h00, 8'h10, 8'h4A, 8'h46, 8'h00};
		send_file();
	endtask

	// An APP0 length of 6 cannot reach a new marker; the trailing byte is ignored.
	task automatic test_short_app0_length();
		file_bytes = '{8'hFF, 8'hD8, 8'hFF, 8'hE0, 8'h00, 8'h06,
			8'h4A, 8'h46, 8'h49, 8'h46, 8'h00, 8'hFF};
		send_file();
	endtask

	// PNG mode with the last signature byte wrong.
	task automatic test_png_bad_signature();
		write_format(FORMAT_PNG);
		file_bytes = '{8'h89, 8'h50, 8'h4E, 8'h00};
		send_file();
	endtask

	// Every one-byte file gives a status request here, so a long hold-off on the output
	// fills both registers and the input must stall. Afterward the sender pauses until
	// every owed status has come.
	task automatic test_output_stall();
		tx_idle = 1'b0;
		stall_request = 1'b1;
		repeat (20) begin
			file_bytes = '{8'h00};
			send_file();
		end
		drain_results();
		tx_idle = 1'b1;
	endtask

	// Phases of random files, each with a freshly written format and its own idling mix.
	task automatic test_random_files();
		int phase_end;
		while (bytes_sent < TOTAL_BYTES) begin
			write_format(1'($urandom_range(0, 1)));
			tx_idle = ($urandom_range(0, 3) != 0);
			rx_idle = ($urandom_range(0, 3) != 0);
			phase_end = bytes_sent + $urandom_range(100, 250);
			while (bytes_sent < phase_end && bytes_sent < TOTAL_BYTES) begin
				if ($urandom_range(0, 9) < 2) begin
					build_noise_file();
				end else if (fmt_png == FORMAT_PNG) begin
					build_png_file();
				end else begin
					build_jpeg_file();
				end
				send_file();
			end
		end
		// Both formats are written once more so the run ends on each extreme.
		write_format(FORMAT_PNG);
		write_format(FORMAT_JPEG);
	endtask

	// The receiver draws a wait before each status request, and honors a long hold-off
	// when the stimulus asks for one.
	initial begin : receiver
		int gap;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (stall_request) begin
				stall_request = 1'b0;
				gap = LONG_STALL_CYCLES;
			end else begin
				gap = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
			end
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	// Each accepted status request is matched against the oldest owed one.
	always @(posedge clk) begin : result_check
		size_report_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_reports.size() == 0) begin
				$error("unexpected status request: status %0d width %h height %h",
					status, width, height);
				error_count++;
			end else begin
				want = expected_reports.pop_front();
				if (status !== want.status) begin
					$error("status mismatch: expected %0d, got %0d", want.status, status);
					error_count++;
				end
				if (width !== want.width) begin
					$error("width mismatch: expected %h, got %h", want.width, width);
					error_count++;
				end
				if (height !== want.height) begin
					$error("height mismatch: expected %h, got %h", want.height, height);
					error_count++;
				end
			end
		end
	end

	// Ends a hung run: too many cycles in a row with no request moving on either side.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_wdata <= FORMAT_JPEG;
		in_valid  <= 1'b0;
		data_byte <= 8'h00;
		last_byte <= 1'b0;
		fmt_png = FORMAT_JPEG;
		restart_file();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_bad_signature();
		test_truncated_header();
		test_bad_jfif_tag();
		test_short_app0_length();
		test_png_bad_signature();
		test_output_stall();
		test_random_files();
		drain_results();
		if (error_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
